### rtl/cycle_count_to_wall_time_core_assert.svh
// Assertion macros for the cycle-count to wall-time core.
// Included by the top level; relies on clk and arst_n in scope.
`ifndef CYCLE_COUNT_TO_WALL_TIME_CORE_ASSERT_SVH
`define CYCLE_COUNT_TO_WALL_TIME_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define C2WT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define C2WT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/c2wt_pkg.sv
// Shared types and constants of the cycle-count to wall-time core.
// No dependencies.
package c2wt_pkg;
	localparam int unsigned DIVIDEND_W = 94;
	localparam int unsigned REM_W      = 32;
	localparam logic [31:0] FREQ_DEFAULT = 32'd200000000;
	localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;

	typedef enum logic [1:0] {
		REG_REF_TIME  = 2'd0,
		REG_REF_COUNT = 2'd1,
		REG_FREQ      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                    valid;
		logic                    below;
		logic [REM_W-1:0]        rem;
		logic [DIVIDEND_W-1:0]   dq;
	} div_t;
endpackage

### rtl/c2wt_if.sv
// Valid/ready channel interfaces for the cycle-count to wall-time core.
// Depends on nothing.
interface c2wt_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_stamp;
	logic [31:0] sample_period;
	logic [31:0] sample_number;
	modport source (output valid, block_stamp, sample_period, sample_number, input ready);
	modport sink   (input valid, block_stamp, sample_period, sample_number, output ready);
endinterface

interface c2wt_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] stamp_ns;
	modport source (output valid, stamp_ns, input ready);
	modport sink   (input valid, stamp_ns, output ready);
endinterface

### rtl/c2wt_div_cell.sv
// One restoring-division cell: retires one quotient bit per item.
// Depends on c2wt_pkg.
module c2wt_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic [31:0]    divisor,
	input  c2wt_pkg::div_t prev,
	output c2wt_pkg::div_t next
);
	logic [c2wt_pkg::REM_W:0]      trial;
	logic                          fits;
	logic [c2wt_pkg::REM_W-1:0]    rem_d;
	logic                          valid_q;
	logic                          below_q;
	logic [c2wt_pkg::REM_W-1:0]    rem_q;
	logic [c2wt_pkg::DIVIDEND_W-1:0] dq_q;

	always_comb begin
		trial = {prev.rem, prev.dq[c2wt_pkg::DIVIDEND_W-1]};
		fits  = trial >= {1'b0, divisor};
		rem_d = fits ? c2wt_pkg::REM_W'(trial - {1'b0, divisor})
		             : trial[c2wt_pkg::REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			below_q <= prev.below;
			rem_q   <= rem_d;
			dq_q    <= {prev.dq[c2wt_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign next = c2wt_pkg::div_t'{valid: valid_q, below: below_q, rem: rem_q, dq: dq_q};
endmodule

### rtl/cycle_count_to_wall_time_core.sv
// Cycle-count to wall-time conversion core, top level.
// Depends on c2wt_pkg, c2wt_if.sv, c2wt_div_cell and the assertion header.
//
// Usage:
//  src carries one item per sample: block_stamp, sample_period, sample_number.
//  dst returns one item per input: stamp_ns, the sample's wall time in ns.
//  Write reference_time (0), reference_count (1) and counter_frequency (2)
//  through wr_en/wr_index/wr_data while the core is idle; a written zero
//  frequency is stored as 200 MHz and index 3 is ignored.
//  From acceptance to dst.valid an item passes a multiply stage, an
//  add/compare stage, two stages forming elapsed*1e9, a row of 94 division
//  cells (one quotient bit each) and the output adder register.
//  Throughput is one item per cycle unless dst stalls; the cell row sets the pipe length.
//  The whole pipe advances together: when dst stalls with a result waiting,
//  every stage holds and src.ready drops; otherwise items flow every cycle.
//  Reset clears all valid flags and returns the registers to 0, 0, 200 MHz.
module cycle_count_to_wall_time_core (
	input  logic        clk,
	input  logic        arst_n,
	c2wt_in_if.sink     src,
	c2wt_out_if.source  dst,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data
);
	`include "cycle_count_to_wall_time_core_assert.svh"

	localparam int unsigned NCELL = c2wt_pkg::DIVIDEND_W;

	logic [63:0] ref_time_q;
	logic [63:0] ref_count_q;
	logic [31:0] freq_q;
	logic        advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_time_q  <= '0;
			ref_count_q <= '0;
			freq_q      <= c2wt_pkg::FREQ_DEFAULT;
		end else if (wr_en) begin
			unique case (c2wt_pkg::reg_idx_t'(wr_index))
				c2wt_pkg::REG_REF_TIME:  ref_time_q  <= wr_data;
				c2wt_pkg::REG_REF_COUNT: ref_count_q <= wr_data;
				c2wt_pkg::REG_FREQ: begin
					freq_q <= (wr_data[31:0] == 32'd0) ? c2wt_pkg::FREQ_DEFAULT
					                                   : wr_data[31:0];
				end
				default: ;
			endcase
		end
	end

	// advance the whole pipe unless a finished item waits at the output
	assign advance   = !dst.valid || dst.ready;
	assign src.ready = advance;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [63:0] stamp_s1, offset_s1;
	logic [63:0] elapsed_s2;
	logic        below_s2, below_s3, below_s4;
	logic [61:0] plo_s3, phi_s3;
	logic [c2wt_pkg::DIVIDEND_W-1:0] dividend_s4;
	logic [63:0] stamp_ns_q;
	logic [63:0] count_d;

	assign count_d = stamp_s1 + offset_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= src.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// sample offset in cycles
			stamp_s1   <= src.block_stamp;
			offset_s1  <= src.sample_number * src.sample_period;
			// sample count, checked against the reference
			below_s2   <= count_d < ref_count_q;
			elapsed_s2 <= count_d - ref_count_q;
			// scale to nanoseconds in two 32-bit halves
			below_s3   <= below_s2;
			plo_s3     <= elapsed_s2[31:0]  * c2wt_pkg::NS_PER_SEC;
			phi_s3     <= elapsed_s2[63:32] * c2wt_pkg::NS_PER_SEC;
			below_s4   <= below_s3;
			dividend_s4 <= {phi_s3, 32'd0} + {32'd0, plo_s3};
		end
	end

	// division cell row: each cell retires one quotient bit
	c2wt_pkg::div_t chain [0:NCELL];

	assign chain[0] = c2wt_pkg::div_t'{valid: v_s4, below: below_s4, rem: '0,
		dq: dividend_s4};

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		c2wt_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.divisor (freq_q),
			.prev    (chain[i]),
			.next    (chain[i+1])
		);
	end

	// output register: drop the quotient for counts before the reference
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chain[NCELL].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stamp_ns_q <= ref_time_q +
			              (chain[NCELL].below ? 64'd0 : chain[NCELL].dq[63:0]);
		end
	end

	assign dst.valid    = out_valid_q;
	assign dst.stamp_ns = stamp_ns_q;

	`C2WT_ASSERT_NOW(a_freq_nonzero, 1'b1, freq_q != 32'd0, "frequency register is zero")
	`C2WT_ASSERT_NEXT(a_enter, src.valid && src.ready, v_s1, "accepted item lost at entry")
	`C2WT_ASSERT_NEXT(a_exit, chain[NCELL].valid && advance, dst.valid, "item lost at output")
	`C2WT_ASSERT_NEXT(a_hold, dst.valid && !dst.ready, v_s1 == $past(v_s1), "pipe moved in stall")
endmodule

### verif/tb_cycle_count_to_wall_time_core.sv
// Testbench for cycle_count_to_wall_time_core: drives sample items, predicts each
// wall-time stamp and checks the results in order. Depends on c2wt_pkg, c2wt_if.sv and the core.
`timescale 1ns / 1ps

module tb_cycle_count_to_wall_time_core;
	// index 3 is not a register; writes to it must be dropped
	localparam logic [1:0]  REG_NONE     = 2'd3;
	localparam logic [63:0] NS_IN_SEC    = 64'd1000000000;
	localparam logic [31:0] HZ_FALLBACK  = 32'd200000000;
	localparam int          PIPE_CYCLES  = 99;
	localparam int          STALL_LIMIT  = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = 2'd0;
	logic [63:0] wr_data = 64'd0;

	c2wt_in_if  src ();
	c2wt_out_if dst ();

	cycle_count_to_wall_time_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src),
		.dst      (dst),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #2 clk = ~clk;

	// Our own copy of the conversion registers, updated on every write.
	logic [63:0] ref_ns_q = 64'd0;
	logic [63:0] ref_cycles_q = 64'd0;
	logic [31:0] hz_q = HZ_FALLBACK;

	logic [63:0] stamps_due[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          timed_out = 1'b0;
	int          burst_left = 0;
	int          rx_mode = 0;
	int unsigned cyc = 0;

	// Wall time of one sample: whole seconds and the fractional part are
	// scaled apart so nothing overflows before the final wrap.
	function automatic logic [63:0] wall_ns(logic [63:0] stamp, logic [31:0] period,
			logic [31:0] number);
		logic [63:0] count;
		logic [63:0] elapsed;
		logic [63:0] hz;
		logic [63:0] secs;
		logic [63:0] frac;
		count = stamp + 64'(number) * 64'(period);
		if (count < ref_cycles_q)
			return ref_ns_q;
		elapsed = count - ref_cycles_q;
		hz = 64'(hz_q);
		secs = elapsed / hz;
		frac = elapsed % hz;
		return ref_ns_q + secs * NS_IN_SEC + (frac * NS_IN_SEC) / hz;
	endfunction

	initial begin
		src.valid = 1'b0;
		src.block_stamp = '0;
		src.sample_period = '0;
		src.sample_number = '0;
		dst.ready = 1'b0;
	end

	// Receiver: switch between stall patterns periodically.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 300 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: dst.ready <= 1'b1;
			1: dst.ready <= ($urandom_range(0, 1) == 1);
			2: dst.ready <= (cyc % 7 >= 3);
			default: dst.ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// Predict on acceptance, compare on delivery, and watch for a hang.
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n) begin
			if (src.valid && src.ready)
				stamps_due.push_back(wall_ns(src.block_stamp, src.sample_period,
					src.sample_number));
			if (dst.valid && dst.ready) begin
				if (stamps_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected stamp_ns %0d", dst.stamp_ns);
				end else begin
					want = stamps_due.pop_front();
					if (dst.stamp_ns !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("stamp_ns mismatch: expected %0d, got %0d",
								want, dst.stamp_ns);
					end
				end
			end
			if ((src.valid && src.ready) || (dst.valid && dst.ready) ||
					(!src.valid && stamps_due.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT && !timed_out) begin
				timed_out = 1'b1;
				$display("[cycle_count_to_wall_time_core] ERROR");
				$finish;
			end
		end
	end

	// Send one item; hold valid high into the next item unless a gap is due.
	task automatic send_sample(logic [63:0] stamp, logic [31:0] period, logic [31:0] number);
		int gap;
		src.valid <= 1'b1;
		src.block_stamp <= stamp;
		src.sample_period <= period;
		src.sample_number <= number;
		do @(posedge clk); while (!src.ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				src.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait until every pending stamp has come back.
	task automatic drain();
		src.valid <= 1'b0;
		@(posedge clk);
		while (stamps_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			c2wt_pkg::REG_REF_TIME:  ref_ns_q = value;
			c2wt_pkg::REG_REF_COUNT: ref_cycles_q = value;
			c2wt_pkg::REG_FREQ:      hz_q = (value[31:0] == 32'd0) ? HZ_FALLBACK : value[31:0];
			default: ;
		endcase
	endtask

	task automatic set_conversion(logic [63:0] t0, logic [63:0] c0, logic [63:0] hz);
		drain();
		write_reg(c2wt_pkg::REG_REF_TIME, t0);
		write_reg(c2wt_pkg::REG_REF_COUNT, c0);
		write_reg(c2wt_pkg::REG_FREQ, hz);
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Field extremes under the reset settings.
	task automatic test_field_extremes();
		send_sample(64'd0, 32'd0, 32'd0);
		send_sample('1, 32'd0, 32'd0);
		send_sample('1, '1, '1);
		send_sample(64'd0, '1, '1);
		send_sample(64'd199999999, 32'd0, 32'd0);
		send_sample(64'd200000000, 32'd0, 32'd0);
		send_sample(64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555, 32'h5555_AAAA);
		send_sample(64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA, 32'hAAAA_5555);
	endtask

	// Counts just below, at and above the reference; wrap of the stamp sum.
	task automatic test_reference_edges();
		set_conversion(64'h1234_5678_9ABC_DEF0, 64'h0000_1000_0000_0000, 64'd100000000);
		send_sample(64'h0000_0FFF_FFFF_FFFF, 32'd0, 32'd0);
		send_sample(64'h0000_1000_0000_0000, 32'd0, 32'd0);
		send_sample(64'h0000_1000_0000_0001, 32'd0, 32'd0);
		send_sample(64'h0000_0FFF_0000_0000, 32'h0001_0000, 32'h0001_0000);
		send_sample('1, 32'd1, 32'd1);
		send_sample(64'd5, 32'd7, 32'd3);
	endtask

	// Zero frequency falls back to 200 MHz; slowest counter wraps the time.
	task automatic test_frequency_settings();
		set_conversion('1, '1, 64'd0);
		send_sample('1, 32'd0, 32'd0);
		send_sample(64'd3, 32'd0, 32'd0);
		set_conversion('1, 64'd0, 64'd1);
		send_sample('1, '1, '1);
		send_sample(64'd1, 32'd0, 32'd0);
		set_conversion(64'd0, 64'd0, 64'hFFFF_FFFF_0000_0000 | 64'hFFFF_FFFF);
		send_sample('1, 32'd0, 32'd0);
		send_sample(64'hFFFF_FFFE, 32'd0, 32'd0);
		// upper data bits of a frequency write must not matter
		set_conversion(64'd0, 64'd0, 64'hDEAD_BEEF_0000_0000);
		send_sample(64'd400000000, 32'd0, 32'd0);
	endtask

	// A write to the unused index leaves every register alone.
	task automatic test_unused_index();
		drain();
		write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
		@(posedge clk);
		send_sample(64'd123456789012, 32'd1000, 32'd77);
		send_sample(64'd0, 32'd0, 32'd0);
	endtask

	// Random items over several settings; stamps cluster around the reference.
	task automatic test_random_traffic(int n_items);
		logic [63:0] stamp;
		logic [31:0] period;
		logic [31:0] number;
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(0, 4))
					0: set_conversion(rand64(), rand64(), 64'($urandom));
					1: set_conversion('1, rand64(), 64'd0);
					2: set_conversion(64'd0, 64'd0, 64'd1);
					3: set_conversion(rand64(), '1, '1);
					default: set_conversion(rand64(), rand64() >> $urandom_range(0, 63),
						64'($urandom_range(1, 1000)));
				endcase
			end
			period = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 5000);
			number = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 300);
			case ($urandom_range(0, 3))
				0: stamp = rand64();
				1: stamp = ref_cycles_q + 64'($urandom_range(0, 1 << 20));
				2: stamp = ref_cycles_q - 64'($urandom_range(0, 1 << 20));
				default: stamp = ref_cycles_q + {32'd0, $urandom} * 64'(hz_q);
			endcase
			send_sample(stamp, period, number);
			// pause once mid-stream until the pipe is empty
			if (i == n_items / 2)
				drain();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_field_extremes();
		test_reference_edges();
		test_frequency_settings();
		test_unused_index();
		test_random_traffic(700);
		drain();
		repeat (PIPE_CYCLES + 20) @(posedge clk);
		if (mismatches == 0 && stamps_due.size() == 0 && !timed_out)
			$display("[cycle_count_to_wall_time_core] OK");
		else
			$display("[cycle_count_to_wall_time_core] ERROR");
		$finish;
	end
endmodule
